@@ src/fsd_pkg.sv @@
package fsd_pkg;

   localparam int LEVEL_W        = 16;
   localparam int COUNT_W        = 8;
   localparam int TALLY_W        = 16;
   localparam int STILL_SUM_W    = 24;
   localparam int PHASE_W        = 2;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int WINDOW_DEPTH_DEF = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_MARGIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_MARGIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_COUNT  = 3'd4;

   localparam logic [LEVEL_W-1:0] ACCEL_MARGIN_RST = 16'd2000;
   localparam logic [LEVEL_W-1:0] GYRO_MARGIN_RST  = 16'd2000;
   localparam logic [LEVEL_W-1:0] STILL_LIMIT_RST  = 16'd100;
   localparam logic [COUNT_W-1:0] SETTLE_COUNT_RST = 8'd5;
   localparam logic [COUNT_W-1:0] STILL_COUNT_RST  = 8'd20;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_CODE_MONITOR = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_INVALID = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic [LEVEL_W-1:0] accel_level;
      logic [LEVEL_W-1:0] gyro_level;
   } req_type;

   typedef struct packed {
      logic [TALLY_W-1:0] falls_total;
      logic               fall_event;
      logic [PHASE_W-1:0] phase_now;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] accel_margin;
      logic [LEVEL_W-1:0] gyro_margin;
      logic [LEVEL_W-1:0] still_limit;
      logic [COUNT_W-1:0] settle_count;
      logic [COUNT_W-1:0] still_count;
   } cfg_type;

endpackage

@@ src/fsd_ram.sv @@
module fsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fsd_window.sv @@
module fsd_window #(
   parameter int WINDOW_DEPTH = fsd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [fsd_pkg::LEVEL_W-1:0] accel_level,
   input  logic [fsd_pkg::LEVEL_W-1:0] gyro_level,
   input  fsd_pkg::cfg_type           cfg,
   output logic                       impact
);
   import fsd_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = LEVEL_W + SLOT_W;
   localparam int CMP_W  = SUM_W + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [CMP_W-1:0]  DEPTH_K   = CMP_W'(WINDOW_DEPTH);

   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               fill_done_ff, fill_done_in;
   logic [SUM_W-1:0]   accel_sum_ff, accel_sum_in;
   logic [SUM_W-1:0]   gyro_sum_ff, gyro_sum_in;
   logic [LEVEL_W-1:0] accel_rd, gyro_rd;
   logic [LEVEL_W-1:0] accel_old, gyro_old;
   logic [SUM_W-1:0]   accel_sum_new, gyro_sum_new;
   logic [CMP_W-1:0]   accel_lhs, accel_rhs, gyro_lhs, gyro_rhs;

   // read port looks one word ahead so the oldest entry is ready on arrival
   fsd_ram #(.WIDTH(LEVEL_W), .DEPTH(WINDOW_DEPTH)) u_accel_ring (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (slot_ff),
      .wr_data (accel_level),
      .rd_addr (slot_in),
      .rd_data (accel_rd)
   );

   fsd_ram #(.WIDTH(LEVEL_W), .DEPTH(WINDOW_DEPTH)) u_gyro_ring (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (slot_ff),
      .wr_data (gyro_level),
      .rd_addr (slot_in),
      .rd_data (gyro_rd)
   );

   // entries not yet written on the first pass read as zero
   assign accel_old = fill_done_ff ? accel_rd : '0;
   assign gyro_old  = fill_done_ff ? gyro_rd  : '0;

   assign accel_sum_new = accel_sum_ff + SUM_W'(accel_level) - SUM_W'(accel_old);
   assign gyro_sum_new  = gyro_sum_ff  + SUM_W'(gyro_level)  - SUM_W'(gyro_old);

   assign accel_lhs = CMP_W'(accel_level) * DEPTH_K;
   assign accel_rhs = CMP_W'(accel_sum_new) + CMP_W'(cfg.accel_margin) * DEPTH_K;
   assign gyro_lhs  = CMP_W'(gyro_level) * DEPTH_K;
   assign gyro_rhs  = CMP_W'(gyro_sum_new) + CMP_W'(cfg.gyro_margin) * DEPTH_K;

   assign impact = (accel_lhs > accel_rhs) && (gyro_lhs > gyro_rhs);

   always_comb begin
      slot_in      = slot_ff;
      fill_done_in = fill_done_ff;
      accel_sum_in = accel_sum_ff;
      gyro_sum_in  = gyro_sum_ff;
      if (reset) begin
         slot_in      = '0;
         fill_done_in = 1'b0;
         accel_sum_in = '0;
         gyro_sum_in  = '0;
      end else if (advance) begin
         accel_sum_in = accel_sum_new;
         gyro_sum_in  = gyro_sum_new;
         if (slot_ff == LAST_SLOT) begin
            slot_in      = '0;
            fill_done_in = 1'b1;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      fill_done_ff <= fill_done_in;
      accel_sum_ff <= accel_sum_in;
      gyro_sum_ff  <= gyro_sum_in;
   end

endmodule

@@ src/fsd_phase.sv @@
module fsd_phase (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic                        cmd,
   input  logic [fsd_pkg::LEVEL_W-1:0] gyro_level,
   input  logic                        impact,
   input  fsd_pkg::cfg_type            cfg,
   output logic                        monitoring,
   output fsd_pkg::rsp_type            result
);
   import fsd_pkg::*;

   typedef enum logic [PHASE_W-1:0] {
      MONITOR = 2'd0,
      SETTLE  = 2'd1,
      STILL   = 2'd2
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [STILL_SUM_W-1:0] still_sum_ff, still_sum_in;
   logic [TALLY_W-1:0]     tally_ff, tally_in;
   logic                   event_in;
   logic [COUNT_W-1:0]     count_inc;
   logic [COUNT_W-1:0]     target;
   logic [STILL_SUM_W-1:0] still_sum_new;
   logic [STILL_SUM_W-1:0] still_bound;

   assign count_inc     = count_ff + COUNT_W'(1);
   assign target        = (cfg.still_count == '0) ? COUNT_W'(1) : cfg.still_count;
   assign still_sum_new = still_sum_ff + STILL_SUM_W'(gyro_level);
   assign still_bound   = STILL_SUM_W'(cfg.still_limit) * STILL_SUM_W'(count_inc);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      still_sum_in = still_sum_ff;
      tally_in     = tally_ff;
      event_in     = 1'b0;
      if (fire) begin
         if (cmd == CMD_CLEAR) begin
            tally_in = '0;
         end else begin
            case (state_ff)
               MONITOR: begin
                  if (impact) begin
                     count_in = '0;
                     if (cfg.settle_count == '0) begin
                        state_in     = STILL;
                        still_sum_in = '0;
                     end else begin
                        state_in = SETTLE;
                     end
                  end
               end
               SETTLE: begin
                  count_in = count_inc;
                  if (count_inc >= cfg.settle_count) begin
                     state_in     = STILL;
                     count_in     = '0;
                     still_sum_in = '0;
                  end
               end
               STILL: begin
                  count_in     = count_inc;
                  still_sum_in = still_sum_new;
                  if (count_inc >= target) begin
                     if (still_sum_new < still_bound) begin
                        event_in = 1'b1;
                        if (tally_ff != '1) begin
                           tally_in = tally_ff + TALLY_W'(1);
                        end
                     end
                     state_in     = MONITOR;
                     count_in     = '0;
                     still_sum_in = '0;
                  end
               end
               default: begin
                  state_in = MONITOR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MONITOR;
         count_ff     <= '0;
         still_sum_ff <= '0;
         tally_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         still_sum_ff <= still_sum_in;
         tally_ff     <= tally_in;
      end
   end

   assign monitoring         = (state_ff == MONITOR);
   assign result.falls_total = tally_in;
   assign result.fall_event  = event_in;
   assign result.phase_now   = state_in;

endmodule

@@ src/impact_stillness_fall_detector.sv @@
// Impact-then-stillness fall detector.
//
// req channel: one word per motion sample (cmd = sample) or a counter clear
// (cmd = clear). A word is taken when req_valid is high and req_stall low.
// rsp channel: exactly one word per request, in order, with the fall count,
// a fall flag and the detector phase. The receiver holds it off with rsp_stall.
// csr channel: register writes by index, always ready; write only while idle.
//
// A request goes from the input register to the output register and on to
// rsp. One word per clock while rsp is not stalled; per-sample updates (ring
// write and running sums while monitoring, phase step) are made as a word
// leaves the input register. When rsp is stalled the input register still
// takes one more word, and req_stall rises only once both are full.
// Reset (synchronous) empties both registers, zeroes the window sums, the
// phase, the counters and the fall count, and restores register defaults.
// The window history needs no clearing pass: slots not yet written on the
// first pass read as zero.
module impact_stillness_fall_detector #(
   parameter int WINDOW_DEPTH = fsd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fsd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fsd_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import fsd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type result;
   logic    out_free;
   logic    fire;
   logic    accept;
   logic    monitoring;
   logic    impact;
   logic    advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign advance   = fire && (in_data_ff.cmd == CMD_SAMPLE) && monitoring;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL_MARGIN: cfg_in.accel_margin = csr_data;
            CSR_GYRO_MARGIN:  cfg_in.gyro_margin  = csr_data;
            CSR_STILL_LIMIT:  cfg_in.still_limit  = csr_data;
            CSR_SETTLE_COUNT: cfg_in.settle_count = csr_data[COUNT_W-1:0];
            CSR_STILL_COUNT:  cfg_in.still_count  = csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_margin <= ACCEL_MARGIN_RST;
         cfg_ff.gyro_margin  <= GYRO_MARGIN_RST;
         cfg_ff.still_limit  <= STILL_LIMIT_RST;
         cfg_ff.settle_count <= SETTLE_COUNT_RST;
         cfg_ff.still_count  <= STILL_COUNT_RST;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   fsd_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .accel_level (in_data_ff.accel_level),
      .gyro_level  (in_data_ff.gyro_level),
      .cfg         (cfg_ff),
      .impact      (impact)
   );

   fsd_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cmd        (in_data_ff.cmd),
      .gyro_level (in_data_ff.gyro_level),
      .impact     (impact),
      .cfg        (cfg_ff),
      .monitoring (monitoring),
      .result     (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ src/fsd_checker.sv @@
module fsd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fsd_pkg::rsp_type rsp_data
);
   import fsd_pkg::*;

   // a fall closes the stillness measurement and returns to monitoring
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fall_event |-> rsp_data.phase_now == PHASE_CODE_MONITOR)
      else $error("fall reported outside monitoring phase");

   // a fall always leaves a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fall_event |-> rsp_data.falls_total != '0)
      else $error("fall reported with zero count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.phase_now != PHASE_CODE_INVALID)
      else $error("unused phase code on rsp");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word dropped or changed");

endmodule

bind impact_stillness_fall_detector fsd_checker u_fsd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
